@@ hw/rtl/pffs_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pffs_pkg
// Shared constants, codes and types for the page frame free stack.
// ----------------------------------------------------------------------------
package pffs_pkg;

    localparam int STORE_DEPTH = 4096;
    localparam int PAGE_SHIFT  = 12;

    localparam int ADDR_W    = 64;
    localparam int PFN_W     = 52;
    localparam int REQ_W     = 2;
    localparam int STS_W     = 2;
    localparam int FCNT_W    = 13;
    localparam int CFG_IDX_W = 8;
    localparam int IDX_W     = $clog2(STORE_DEPTH);
    localparam int CNT_W     = $clog2(STORE_DEPTH + 1);

    typedef logic [ADDR_W-1:0]    t_addr;
    typedef logic [PFN_W-1:0]     t_pfn;
    typedef logic [REQ_W-1:0]     t_req;
    typedef logic [STS_W-1:0]     t_sts;
    typedef logic [FCNT_W-1:0]    t_fcnt;
    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;
    typedef logic [IDX_W-1:0]     t_idx;
    typedef logic [CNT_W-1:0]     t_cnt;

    localparam t_cnt DEPTH_CNT = CNT_W'(STORE_DEPTH);

    localparam t_req REQ_ALLOC = 2'd0;
    localparam t_req REQ_FREE  = 2'd1;
    localparam t_req REQ_BUILD = 2'd2;

    localparam t_sts ST_OK     = 2'd0;
    localparam t_sts ST_EMPTY  = 2'd1;
    localparam t_sts ST_REJECT = 2'd2;
    localparam t_sts ST_FULL   = 2'd3;

    localparam t_cfg_idx CFG_START = 8'd0;
    localparam t_cfg_idx CFG_END   = 8'd1;

    typedef struct packed {
        logic accept;
        logic build_step;
        logic finish;
    } t_cmd;

    typedef struct packed {
        logic req_is_build;
        logic bld_more;
        logic bld_full;
        logic out_free;
    } t_stat;

endpackage

@@ hw/rtl/pffs_cfg_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pffs_cfg_if
// Register write channel: index and data with valid/ready.
// ----------------------------------------------------------------------------
interface pffs_cfg_if import pffs_pkg::*; ();
    logic     valid;
    logic     ready;
    t_cfg_idx index;
    t_pfn     data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

@@ hw/rtl/pffs_req_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pffs_req_if
// Request channel: request type and byte address with valid/ready.
// ----------------------------------------------------------------------------
interface pffs_req_if import pffs_pkg::*; ();
    logic  valid;
    logic  ready;
    t_req  req_type;
    t_addr address;

    modport source (output valid, output req_type, output address, input ready);
    modport sink   (input valid, input req_type, input address, output ready);
endinterface

@@ hw/rtl/pffs_rsp_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pffs_rsp_if
// Result channel: page address, status and free count with valid/ready.
// ----------------------------------------------------------------------------
interface pffs_rsp_if import pffs_pkg::*; ();
    logic  valid;
    logic  ready;
    t_addr page_address;
    t_sts  status;
    t_fcnt free_count;

    modport source (output valid, output page_address, output status,
                    output free_count, input ready);
    modport sink   (input valid, input page_address, input status,
                    input free_count, output ready);
endinterface

@@ hw/rtl/pffs_ram.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pffs_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module pffs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

@@ hw/rtl/pffs_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pffs_ctrl
// Request sequencer: accept, single-entry finish, rebuild walk.
// ----------------------------------------------------------------------------
module pffs_ctrl import pffs_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_req_valid,
    output logic  o_req_ready,
    input  t_stat i_stat,
    output t_cmd  o_cmd
);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_FIN   = 2'd1;
    localparam logic [1:0] S_BUILD = 2'd2;

    logic [1:0] r_state;
    logic [1:0] n_state;

    always_comb begin
        n_state     = r_state;
        o_cmd       = '0;
        o_req_ready = (r_state == S_IDLE);
        unique case (r_state)
            S_IDLE: begin
                if (i_req_valid) begin
                    o_cmd.accept = 1'b1;
                    n_state      = i_stat.req_is_build ? S_BUILD : S_FIN;
                end
            end
            S_FIN: begin
                if (i_stat.out_free) begin
                    o_cmd.finish = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            S_BUILD: begin
                if (i_stat.bld_more && !i_stat.bld_full) begin
                    o_cmd.build_step = 1'b1;
                end else if (i_stat.out_free) begin
                    o_cmd.finish = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

@@ hw/rtl/pffs_dp.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pffs_dp
// Datapath: region registers, stack pointer, page store, result register.
// ----------------------------------------------------------------------------
module pffs_dp import pffs_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_cmd     i_cmd,
    output t_stat    o_stat,
    input  t_req     i_req_type,
    input  t_addr    i_address,
    input  logic     i_cfg_valid,
    input  t_cfg_idx i_cfg_index,
    input  t_pfn     i_cfg_data,
    output logic     o_rsp_valid,
    input  logic     i_rsp_ready,
    output t_addr    o_page_address,
    output t_sts     o_status,
    output t_fcnt    o_free_count
);

    t_pfn  r_start;
    t_pfn  r_end;
    t_cnt  r_top;
    t_cnt  n_top;
    t_req  r_req;
    t_addr r_addr;
    t_pfn  r_p;
    logic  r_out_valid;
    t_addr r_out_addr;
    t_addr n_out_addr;
    t_sts  r_out_sts;
    t_sts  n_out_sts;
    t_fcnt r_out_cnt;

    t_cnt  w_top_m1;
    t_addr w_pfn;
    logic  w_free_ok;
    logic  w_full;
    logic  w_more;
    logic  w_wr_en;
    t_pfn  w_wr_data;
    logic  w_rd_en;
    t_pfn  w_rd_data;

    assign w_top_m1  = r_top - t_cnt'(1);
    assign w_pfn     = r_addr >> PAGE_SHIFT;
    assign w_full    = (r_top == DEPTH_CNT);
    assign w_more    = ({1'b0, r_p} + (PFN_W + 1)'(1)) < {1'b0, r_end};
    assign w_free_ok = (r_addr[PAGE_SHIFT-1:0] == '0)
                       && (w_pfn >= ADDR_W'(r_start))
                       && (w_pfn < ADDR_W'(r_end));

    assign w_rd_en   = i_cmd.accept && (i_req_type == REQ_ALLOC);
    assign w_wr_en   = i_cmd.build_step
                       || (i_cmd.finish && (r_req == REQ_FREE) && w_free_ok && !w_full);
    assign w_wr_data = i_cmd.build_step ? r_p : w_pfn[PFN_W-1:0];

    pffs_ram #(
        .WIDTH (PFN_W),
        .DEPTH (STORE_DEPTH)
    ) u_store (
        .i_clk     (i_clk),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (r_top[IDX_W-1:0]),
        .i_wr_data (w_wr_data),
        .i_rd_en   (w_rd_en),
        .i_rd_addr (w_top_m1[IDX_W-1:0]),
        .o_rd_data (w_rd_data)
    );

    always_comb begin
        o_stat.req_is_build = (i_req_type == REQ_BUILD);
        o_stat.bld_more     = w_more;
        o_stat.bld_full     = w_full;
        o_stat.out_free     = !r_out_valid || i_rsp_ready;
    end

    // result and pointer update of a finishing request
    always_comb begin
        n_top      = r_top;
        n_out_addr = '0;
        n_out_sts  = ST_OK;
        unique case (r_req)
            REQ_ALLOC: begin
                if (r_top == '0) begin
                    n_out_sts = ST_EMPTY;
                end else begin
                    n_top      = w_top_m1;
                    n_out_addr = ADDR_W'(w_rd_data) << PAGE_SHIFT;
                end
            end
            REQ_FREE: begin
                if (!w_free_ok) begin
                    n_out_sts = ST_REJECT;
                end else if (w_full) begin
                    n_out_sts = ST_FULL;
                end else begin
                    n_top = r_top + t_cnt'(1);
                end
            end
            REQ_BUILD: begin
                n_out_sts = w_more ? ST_FULL : ST_OK;
            end
            default: begin
                n_out_sts = ST_OK;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start     <= '0;
            r_end       <= '0;
            r_top       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_valid && (i_cfg_index == CFG_START)) begin
                r_start <= i_cfg_data;
            end
            if (i_cfg_valid && (i_cfg_index == CFG_END)) begin
                r_end <= i_cfg_data;
            end
            if (i_cmd.accept && (i_req_type == REQ_BUILD)) begin
                r_top <= '0;
            end else if (i_cmd.build_step) begin
                r_top <= r_top + t_cnt'(1);
            end else if (i_cmd.finish) begin
                r_top <= n_top;
            end
            if (i_cmd.finish) begin
                r_out_valid <= 1'b1;
            end else if (i_rsp_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_req  <= i_req_type;
            r_addr <= i_address;
            r_p    <= r_start;
        end else if (i_cmd.build_step) begin
            r_p <= r_p + t_pfn'(1);
        end
        if (i_cmd.finish) begin
            r_out_addr <= n_out_addr;
            r_out_sts  <= n_out_sts;
            r_out_cnt  <= FCNT_W'(n_top);
        end
    end

    assign o_rsp_valid    = r_out_valid;
    assign o_page_address = r_out_addr;
    assign o_status       = r_out_sts;
    assign o_free_count   = r_out_cnt;

    a_top_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_top <= DEPTH_CNT)
        else $error("stack pointer past store depth");

    a_step_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.build_step |-> (!w_full && w_more))
        else $error("rebuild push without room or pages");

    a_finish_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.finish |=> r_out_valid)
        else $error("finished request left no result");

    a_pop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.finish && (r_req == REQ_ALLOC) && (r_top != '0))
        |=> (r_top == $past(w_top_m1)))
        else $error("allocate did not pop one entry");

    a_finish_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.finish |-> (!r_out_valid || i_rsp_ready))
        else $error("result overwritten while pending");

endmodule

@@ hw/rtl/page_frame_free_stack.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// page_frame_free_stack
// LIFO page frame allocator with region rebuild, top level.
// ----------------------------------------------------------------------------
//  channel   dir   handshake       payload
//  i_cfg     in    valid / ready   index, data (region start / end page)
//  i_req     in    valid / ready   req_type, address
//  o_rsp     out   valid / ready   page_address, status, free_count
//
//  allocate and free: accept (allocate reads the store), then result (free writes it)
//  rebuild: accept, then one store write per page pushed, then the result
//  no clearing pass after reset; only store entries below the pointer are returned
//  a new request is accepted while the previous result waits in o_rsp
//  a stalled o_rsp holds the finishing request until the result register frees
// ----------------------------------------------------------------------------
module page_frame_free_stack import pffs_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    pffs_cfg_if.sink    i_cfg,
    pffs_req_if.sink    i_req,
    pffs_rsp_if.source  o_rsp
);

    t_cmd  w_cmd;
    t_stat w_stat;

    assign i_cfg.ready = 1'b1;

    pffs_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req.valid),
        .o_req_ready (i_req.ready),
        .i_stat      (w_stat),
        .o_cmd       (w_cmd)
    );

    pffs_dp u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (w_cmd),
        .o_stat         (w_stat),
        .i_req_type     (i_req.req_type),
        .i_address      (i_req.address),
        .i_cfg_valid    (i_cfg.valid),
        .i_cfg_index    (i_cfg.index),
        .i_cfg_data     (i_cfg.data),
        .o_rsp_valid    (o_rsp.valid),
        .i_rsp_ready    (o_rsp.ready),
        .o_page_address (o_rsp.page_address),
        .o_status       (o_rsp.status),
        .o_free_count   (o_rsp.free_count)
    );

endmodule

@@ verif/page_frame_free_stack_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// page_frame_free_stack_checker
// Watches the register, request and result channels of the page frame free
// stack. Keeps its own copy of the free page store and region, works out the
// result of every accepted request and compares each result transfer, field
// by field, with the oldest outstanding prediction.
// ----------------------------------------------------------------------------
module page_frame_free_stack_checker import pffs_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    pffs_cfg_if  i_cfg,
    pffs_req_if  i_req,
    pffs_rsp_if  i_rsp,
    output int   o_fail_count,
    output int   o_result_count,
    output int   o_pending
);

    typedef struct packed {
        t_addr page_address;
        t_sts  status;
        t_fcnt free_count;
    } t_page_result;

    t_pfn         free_pages [STORE_DEPTH];
    int unsigned  page_count;
    t_pfn         start_pfn;
    t_pfn         end_pfn;
    t_page_result predicted_results [$];

    function automatic bit push_free_page(t_pfn pfn);
        if (page_count >= STORE_DEPTH) begin
            return 1'b0;
        end
        free_pages[page_count[IDX_W-1:0]] = pfn;
        page_count++;
        return 1'b1;
    endfunction

    function automatic t_page_result predict_allocator(t_req kind, t_addr addr);
        t_page_result     res;
        t_pfn             pfn;
        longint unsigned  walk;
        res        = '0;
        res.status = ST_OK;
        case (kind)
            REQ_ALLOC: begin
                if (page_count == 0) begin
                    res.status = ST_EMPTY;
                end else begin
                    page_count--;
                    res.page_address = t_addr'(free_pages[page_count[IDX_W-1:0]])
                                       << PAGE_SHIFT;
                end
            end
            REQ_FREE: begin
                pfn = t_pfn'(addr >> PAGE_SHIFT);
                if (addr[PAGE_SHIFT-1:0] != '0 || pfn < start_pfn || pfn >= end_pfn) begin
                    res.status = ST_REJECT;
                end else if (!push_free_page(pfn)) begin
                    res.status = ST_FULL;
                end
            end
            REQ_BUILD: begin
                page_count = 0;
                walk = 64'(start_pfn);
                while (walk + 1 < end_pfn && res.status == ST_OK) begin
                    if (!push_free_page(t_pfn'(walk))) begin
                        res.status = ST_FULL;
                    end
                    walk++;
                end
            end
            default: ;
        endcase
        res.free_count = t_fcnt'(page_count);
        return res;
    endfunction

    task automatic note_failure(string msg);
        if (o_fail_count < 10) begin
            $display("[%0t] %s", $realtime, msg);
        end
        o_fail_count++;
    endtask

    always @(posedge i_clk) begin : watch
        t_page_result got;
        t_page_result want;
        if (!i_rst_n) begin
            page_count     = 0;
            start_pfn      = '0;
            end_pfn        = '0;
            o_fail_count   = 0;
            o_result_count = 0;
            predicted_results.delete();
        end else begin
            if (i_rsp.valid && i_rsp.ready) begin
                got.page_address = i_rsp.page_address;
                got.status       = i_rsp.status;
                got.free_count   = i_rsp.free_count;
                o_result_count++;
                if (predicted_results.size() == 0) begin
                    note_failure($sformatf("unexpected result: addr %h status %0d count %0d",
                                           got.page_address, got.status, got.free_count));
                end else begin
                    want = predicted_results.pop_front();
                    if (got.page_address !== want.page_address || got.status !== want.status
                            || got.free_count !== want.free_count) begin
                        note_failure($sformatf({"mismatch: expected addr %h status %0d count %0d,",
                                                " got addr %h status %0d count %0d"},
                                               want.page_address, want.status, want.free_count,
                                               got.page_address, got.status, got.free_count));
                    end
                end
            end
            if (i_cfg.valid && i_cfg.ready) begin
                case (i_cfg.index)
                    CFG_START: start_pfn = i_cfg.data;
                    CFG_END:   end_pfn   = i_cfg.data;
                    default: ;
                endcase
            end
            if (i_req.valid && i_req.ready) begin
                predicted_results.push_back(predict_allocator(i_req.req_type, i_req.address));
            end
        end
        o_pending <= predicted_results.size();
    end

endmodule

@@ verif/page_frame_free_stack_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// page_frame_free_stack_tb
// Drives the page frame free stack with a directed run over the region and
// status corner cases, then random request mixes over many region settings
// under three idling mixes, with one long result stall. The checker beside
// the block predicts and compares; this module makes stimulus and decides.
// ----------------------------------------------------------------------------
module page_frame_free_stack_tb;
    import pffs_pkg::*;

    localparam t_pfn PFN_MAX     = '1;
    localparam t_req REQ_UNUSED  = 2'd3;
    localparam int   CYCLE_LIMIT = 600000;
    localparam int   HOLD_CYCLES = 300;

    logic i_clk;
    logic i_rst_n;

    pffs_cfg_if cfg_bus ();
    pffs_req_if req_bus ();
    pffs_rsp_if rsp_bus ();

    int fail_count;
    int result_count;
    int pending;
    int cycle_count  = 0;
    int items_sent   = 0;
    int settings_used = 0;
    int tx_idle_pct  = 0;
    int rx_idle_pct  = 0;
    bit hold_go      = 1'b0;
    bit hold_done    = 1'b0;

    page_frame_free_stack i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg_bus),
        .i_req   (req_bus),
        .o_rsp   (rsp_bus)
    );

    page_frame_free_stack_checker i_checker (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg          (cfg_bus),
        .i_req          (req_bus),
        .i_rsp          (rsp_bus),
        .o_fail_count   (fail_count),
        .o_result_count (result_count),
        .o_pending      (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding", cycle_count, pending);
            $display("FAILED: results differ");
            $finish;
        end
    end

    // result side: random back-pressure, plus one long hold-off
    initial begin : result_side
        rsp_bus.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_go && !hold_done) begin
                hold_done = 1'b1;
                rsp_bus.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end else begin
                rsp_bus.ready <= ($urandom_range(99) >= rx_idle_pct);
            end
        end
    end

    function automatic t_addr page_addr(t_pfn pfn);
        return t_addr'(pfn) << PAGE_SHIFT;
    endfunction

    task automatic send_request(t_req kind, t_addr addr);
        if ($urandom_range(99) < tx_idle_pct) begin
            req_bus.valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < tx_idle_pct);
        end
        req_bus.valid    <= 1'b1;
        req_bus.req_type <= kind;
        req_bus.address  <= addr;
        do @(posedge i_clk); while (!req_bus.ready);
        items_sent++;
    endtask

    task automatic drain_results();
        req_bus.valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_register(t_cfg_idx idx, t_pfn value);
        cfg_bus.valid <= 1'b1;
        cfg_bus.index <= idx;
        cfg_bus.data  <= value;
        do @(posedge i_clk); while (!cfg_bus.ready);
    endtask

    task automatic write_region(t_pfn first, t_pfn past_end);
        drain_results();
        write_register(CFG_START, first);
        write_register(CFG_END, past_end);
        cfg_bus.valid <= 1'b0;
        settings_used++;
    endtask

    task automatic run_region_block(bit overflow, int n_items);
        t_pfn        first;
        t_pfn        past_end;
        t_pfn        pfn;
        t_addr       addr;
        t_req        kind;
        int unsigned roll;
        int unsigned pick;
        int unsigned span;
        roll = $urandom_range(99);
        span = $urandom_range(0, 40);
        if (overflow) begin
            first    = t_pfn'($urandom_range(0, 1 << 20));
            past_end = first + 4097 + $urandom_range(0, 6);
        end else if (roll < 50) begin
            first    = t_pfn'($urandom_range(0, 4096));
            past_end = first + span;
        end else if (roll < 80) begin
            first = t_pfn'({$urandom, $urandom});
            if (first > PFN_MAX - 64) begin
                first = PFN_MAX - 64;
            end
            past_end = first + span;
        end else if (roll < 92) begin
            first    = PFN_MAX - span;
            past_end = PFN_MAX;
        end else begin
            first    = t_pfn'($urandom_range(100, 5000));
            past_end = first - $urandom_range(1, 50);
        end
        write_region(first, past_end);
        send_request(REQ_BUILD, {$urandom, $urandom});
        repeat (n_items) begin
            roll = $urandom_range(99);
            pick = $urandom_range(99);
            addr = {$urandom, $urandom};
            pfn  = first;
            if (past_end > first) begin
                pfn = first + t_pfn'({$urandom, $urandom}) % (past_end - first);
            end
            if (roll < 40) begin
                kind = REQ_ALLOC;
            end else if (roll < 92) begin
                kind = REQ_FREE;
                if (pick < 70 && past_end > first) begin
                    addr = page_addr(pfn);
                end else if (pick < 80) begin
                    addr = page_addr(first - 1);
                end else if (pick < 88) begin
                    addr = page_addr(past_end);
                end else if (pick < 94) begin
                    addr = page_addr(pfn) | t_addr'($urandom_range(1, (1 << PAGE_SHIFT) - 1));
                end
            end else if (roll < 96) begin
                kind = REQ_BUILD;
            end else begin
                kind = REQ_UNUSED;
            end
            send_request(kind, addr);
        end
    endtask

    task automatic run_phase(int tx_pct, int rx_pct, int total, bit with_hold);
        int left;
        int n;
        tx_idle_pct = tx_pct;
        rx_idle_pct = rx_pct;
        run_region_block(1'b1, 24);
        left = total - 24;
        if (with_hold) begin
            hold_go = 1'b1;
        end
        while (left > 0) begin
            n = $urandom_range(20, 80);
            if (n > left) begin
                n = left;
            end
            run_region_block(1'b0, n);
            left -= n;
        end
    endtask

    initial begin : stimulus
        cfg_bus.valid    <= 1'b0;
        cfg_bus.index    <= CFG_START;
        cfg_bus.data     <= '0;
        req_bus.valid    <= 1'b0;
        req_bus.req_type <= REQ_ALLOC;
        req_bus.address  <= '0;
        i_rst_n          <= 1'b0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // empty store, zero region, unused code
        send_request(REQ_ALLOC, '0);
        send_request(REQ_UNUSED, '1);
        send_request(REQ_FREE, '0);
        send_request(REQ_BUILD, '0);

        // small region: bounds, misaligned, pop until empty
        write_region(16, 21);
        send_request(REQ_BUILD, '0);
        send_request(REQ_ALLOC, '0);
        send_request(REQ_FREE, page_addr(19) | 1);
        send_request(REQ_FREE, page_addr(21));
        send_request(REQ_FREE, page_addr(15));
        send_request(REQ_FREE, page_addr(20));
        send_request(REQ_FREE, page_addr(16));
        repeat (6) send_request(REQ_ALLOC, '0);

        // region at the top of the page number range
        write_region(PFN_MAX - 3, PFN_MAX);
        send_request(REQ_BUILD, '0);
        send_request(REQ_FREE, page_addr(PFN_MAX - 1));
        send_request(REQ_FREE, page_addr(PFN_MAX));
        send_request(REQ_ALLOC, '0);

        write_region(PFN_MAX, PFN_MAX);
        send_request(REQ_BUILD, '0);
        write_region(100, 50);
        send_request(REQ_BUILD, '0);

        // rebuild overflow, free into a full store
        write_region(0, 5000);
        send_request(REQ_BUILD, '0);
        send_request(REQ_FREE, page_addr(1));
        send_request(REQ_ALLOC, '0);
        write_region(0, 4097);
        send_request(REQ_BUILD, '0);

        run_phase(12, 78, 610, 1'b1);
        run_phase(78, 12, 610, 1'b0);
        run_phase(0, 0, 610, 1'b0);

        drain_results();
        repeat (4) @(posedge i_clk);
        $display("covered %0d requests over %0d region settings, %0d results checked",
                 items_sent, settings_used, result_count);
        $display("sender/receiver idle 12/78, 78/12 and none, one %0d-cycle result stall",
                 HOLD_CYCLES);
        if (fail_count == 0 && pending == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule

@@ files.f @@
hw/rtl/pffs_pkg.sv
hw/rtl/pffs_cfg_if.sv
hw/rtl/pffs_req_if.sv
hw/rtl/pffs_rsp_if.sv
hw/rtl/pffs_ram.sv
hw/rtl/pffs_ctrl.sv
hw/rtl/pffs_dp.sv
hw/rtl/page_frame_free_stack.sv
verif/page_frame_free_stack_checker.sv
verif/page_frame_free_stack_tb.sv
